// ===== sv/sha256_pkg.sv =====
// SHA-256 hasher package: round constants, initial hash, helper functions.
// Used by the controller, the datapath and the top level. No dependencies.
package sha256_pkg;

  localparam int unsigned LengthBitsDefault = 61;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StRound = 5'b00010,
    StPad   = 5'b00100,
    StFinal = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  // Round source: block buffer or padded block
  typedef enum logic [1:0] {
    SrcBuf  = 2'd0,
    SrcPad1 = 2'd1,
    SrcPadL = 2'd2
  } src_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       store_byte;
    logic       start_blk;
    logic       round_en;
    logic [5:0] round_idx;
    logic       fold;
    src_e       src;
    logic       clear_msg;
  } cmd_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== sv/sha256_ctrl.sv =====
// SHA-256 controller: sequences block compression, padding and digest output.
// Depends on sha256_pkg.
module sha256_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_acc_i,
  input  logic              byte_valid_i,
  input  logic              is_last_i,
  input  logic [5:0]        fill_i,
  input  logic              out_stall_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output logic [2:0]        out_idx_o,
  output sha256_pkg::cmd_t  cmd_o
);

  sha256_pkg::state_e state_q, state_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] idx_q, idx_d;
  logic       final_q, final_d;   // compressing for the digest
  logic       two_q, two_d;       // second pad block pending
  sha256_pkg::src_e src_q, src_d;

  assign in_stall_o  = (state_q != sha256_pkg::StIdle);
  assign out_valid_o = (state_q == sha256_pkg::StOut);
  assign out_idx_o   = idx_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    final_d = final_q;
    two_d   = two_q;
    src_d   = src_q;
    cmd_o   = '0;
    cmd_o.src       = src_q;
    cmd_o.round_idx = rnd_q;
    case (state_q)
      sha256_pkg::StIdle: begin
        if (in_acc_i) begin
          cmd_o.store_byte = byte_valid_i;
          if (byte_valid_i && fill_i == 6'd63) begin
            src_d   = sha256_pkg::SrcBuf;
            final_d = is_last_i;
            two_d   = 1'b0;
            cmd_o.start_blk = 1'b1;
            rnd_d   = '0;
            state_d = sha256_pkg::StRound;
          end else if (is_last_i) begin
            state_d = sha256_pkg::StPad;
          end
        end
      end
      sha256_pkg::StPad: begin
        // fill_i now holds the final count; after the first of two pad
        // blocks, load the length block
        final_d = 1'b1;
        if (src_q == sha256_pkg::SrcPad1) begin
          two_d = 1'b0;
          src_d = sha256_pkg::SrcPadL;
        end else begin
          two_d = (fill_i > 6'd55);
          src_d = (fill_i > 6'd55) ? sha256_pkg::SrcPad1 : sha256_pkg::SrcPadL;
        end
        cmd_o.start_blk = 1'b1;
        rnd_d   = '0;
        state_d = sha256_pkg::StRound;
      end
      sha256_pkg::StRound: begin
        cmd_o.round_en = 1'b1;
        rnd_d = rnd_q + 6'd1;
        if (rnd_q == 6'd63) state_d = sha256_pkg::StFinal;
      end
      sha256_pkg::StFinal: begin
        cmd_o.fold = 1'b1;
        rnd_d = '0;
        idx_d = '0;
        if (src_q == sha256_pkg::SrcBuf && final_q) begin
          state_d = sha256_pkg::StPad;
        end else if (src_q == sha256_pkg::SrcPad1 && two_q) begin
          two_d = 1'b0;
          state_d = sha256_pkg::StPad;
        end else if (final_q && src_q == sha256_pkg::SrcPadL) begin
          state_d = sha256_pkg::StOut;
        end else begin
          state_d = sha256_pkg::StIdle;
        end
      end
      sha256_pkg::StOut: begin
        if (!out_stall_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            cmd_o.clear_msg = 1'b1;
            final_d = 1'b0;
            state_d = sha256_pkg::StIdle;
          end
        end
      end
      default: state_d = sha256_pkg::StIdle;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha256_pkg::StIdle;
      rnd_q   <= '0;
      idx_q   <= '0;
      final_q <= 1'b0;
      two_q   <= 1'b0;
      src_q   <= sha256_pkg::SrcBuf;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      final_q <= final_d;
      two_q   <= two_d;
      src_q   <= src_d;
    end
  end

endmodule

// ===== sv/sha256_dp.sv =====
// SHA-256 datapath: block buffer, schedule window, round unit, chaining words.
// Depends on sha256_pkg.
module sha256_dp #(
  parameter int unsigned LengthBits = sha256_pkg::LengthBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sha256_pkg::cmd_t cmd_i,
  input  logic [7:0]       msg_byte_i,
  input  logic [2:0]       out_idx_i,
  output logic [5:0]       fill_o,
  output logic [31:0]      digest_o
);

  // Block buffer held as sixteen big-endian words
  logic [31:0] buf_q [16];
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [5:0]  fill_q;
  logic [LengthBits-1:0] total_q;

  assign fill_o   = fill_q;
  assign digest_o = h_q[out_idx_i];

  // Padded-block byte for a position
  function automatic logic [7:0] blk_byte(input logic [5:0] p, input sha256_pkg::src_e s,
                                          input logic [5:0] n, input logic [7:0] b,
                                          input logic [63:0] bits);
    logic [7:0] r;
    r = 8'h00;
    if (s == sha256_pkg::SrcBuf) r = b;
    else if (s == sha256_pkg::SrcPadL && n > 6'd55) begin
      // second pad block: zeros and the length only
      if (p >= 6'd56) r = bits[8*(63-p) +: 8];
    end else begin
      if (p < n) r = b;
      else if (p == n) r = sha256_pkg::PadByte;
      if (s == sha256_pkg::SrcPadL && p >= 6'd56) r = bits[8*(63-p) +: 8];
    end
    return r;
  endfunction

  logic [63:0] bits;
  assign bits = 64'({total_q, 3'b000});

  // Message word for round t < 16
  logic [31:0] wt;
  logic [31:0] wnew;
  logic [5:0]  t;
  assign t = cmd_i.round_idx;
  always_comb begin
    logic [5:0] p;
    for (int k = 0; k < 4; k++) begin
      p = {t[3:0], 2'(k)};
      wnew[8*(3-k) +: 8] = blk_byte(p, cmd_i.src, fill_q, buf_q[t[3:0]][8*(3-k) +: 8], bits);
    end
  end

  logic [31:0] s0w, s1w;
  assign s0w = sha256_pkg::rotr(w_q[1], 7) ^ sha256_pkg::rotr(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1w = sha256_pkg::rotr(w_q[14], 17) ^ sha256_pkg::rotr(w_q[14], 19) ^ (w_q[14] >> 10);
  assign wt = (t < 6'd16) ? wnew : (s1w + w_q[9] + s0w + w_q[0]);

  // Round function
  logic [31:0] t1, t2, bs1, bs0, ch, maj;
  assign bs1 = sha256_pkg::rotr(v_q[4], 6) ^ sha256_pkg::rotr(v_q[4], 11)
             ^ sha256_pkg::rotr(v_q[4], 25);
  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign t1  = v_q[7] + bs1 + ch + sha256_pkg::RoundK[t] + wt;
  assign bs0 = sha256_pkg::rotr(v_q[0], 2) ^ sha256_pkg::rotr(v_q[0], 13)
             ^ sha256_pkg::rotr(v_q[0], 22);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2  = bs0 + maj;

  // Buffer writes, one byte lane at a time
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_byte) buf_q[fill_q[5:2]][8*(3-int'(fill_q[1:0])) +: 8] <= msg_byte_i;
  end

  // Schedule shift window and working variables
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_blk) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.round_en) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wt;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  // Chaining words, fill and length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::InitHash[i];
      fill_q  <= '0;
      total_q <= '0;
    end else begin
      if (cmd_i.fold) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (cmd_i.store_byte) begin
        fill_q <= fill_q + 6'd1;
        if (total_q != {LengthBits{1'b1}}) total_q <= total_q + 1'b1;
      end
      if (cmd_i.clear_msg) begin
        for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::InitHash[i];
        fill_q  <= '0;
        total_q <= '0;
      end
    end
  end

endmodule

// ===== sv/sha256_message_hasher_unit.sv =====
// SHA-256 message hasher top level: controller plus datapath.
// Depends on sha256_pkg, sha256_ctrl, sha256_dp.
//
//  channel | handshake and first field              | other fields
//  in      | in_valid_i in_stall_o msg_byte_i         | byte_valid_i is_last_i
//  out     | out_valid_o out_stall_i digest_word_o    | word_index_o last_word_o
//
// A byte that neither completes a block nor is last leaves the unit idle. A full
// block is loaded in the accepting cycle, then runs 64 rounds of the single round unit and one fold.
// A last item adds one or two padded blocks (each a load, 64 rounds and a fold),
// then eight words.
// Reset loads the initial hash and clears counters; no clearing pass.
// Input is stalled while a block compresses or the digest is delivered.
module sha256_message_hasher_unit #(
  parameter int unsigned LengthBits = sha256_pkg::LengthBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  msg_byte_i,
  input  logic        byte_valid_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  sha256_pkg::cmd_t cmd;
  logic [5:0] fill;
  logic       in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  sha256_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_acc_i(in_acc), .byte_valid_i, .is_last_i,
    .fill_i(fill), .out_stall_i, .in_stall_o, .out_valid_o,
    .out_idx_o(word_index_o), .cmd_o(cmd)
  );

  sha256_dp #(.LengthBits(LengthBits)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .msg_byte_i,
    .out_idx_i(word_index_o), .fill_o(fill), .digest_o(digest_word_o)
  );

  assign last_word_o = (word_index_o == 3'd7);

  // No new transaction accepted while digest words are pending
  a_no_in_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken during output");

  // Digest words leave in order
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && word_index_o != 3'd7) |=>
      (out_valid_o && word_index_o == $past(word_index_o) + 3'd1))
    else $error("word index skipped");

  // Last word returns to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_word_o) |=> !out_valid_o && !in_stall_o)
    else $error("no return to idle");

endmodule
